@@ rtl/mcsp_pkg.sv @@
// ============================================================================
// mcsp_pkg - shared definitions for the memory card serial protocol unit
// Command and reply byte codes, sector store geometry and the store
// access request that passes between the protocol logic and the store.
// ============================================================================
package mcsp_pkg;

  // Store geometry
  localparam int SECTOR_BYTES = 128;
  localparam int SECTOR_COUNT = 1024;
  localparam int OFFSET_W     = $clog2(SECTOR_BYTES);
  localparam int SECTOR_W     = $clog2(SECTOR_COUNT);
  localparam int STORE_ADDR_W = SECTOR_W + OFFSET_W;
  localparam int STORE_DEPTH  = SECTOR_BYTES * SECTOR_COUNT;

  // Host command bytes
  localparam logic [7:0] CMD_SELECT = 8'h81;
  localparam logic [7:0] CMD_READ   = 8'h52;
  localparam logic [7:0] CMD_WRITE  = 8'h57;
  localparam logic [7:0] CMD_GET_ID = 8'h53;

  // Card reply bytes
  localparam logic [7:0] REPLY_IDLE = 8'hFF;
  localparam logic [7:0] REPLY_ID1  = 8'h5A;
  localparam logic [7:0] REPLY_ID2  = 8'h5D;
  localparam logic [7:0] REPLY_ACK1 = 8'h5C;
  localparam logic [7:0] REPLY_ACK2 = 8'h5D;
  localparam logic [7:0] REPLY_END  = 8'h47;
  localparam logic [7:0] REPLY_ZERO = 8'h00;
  localparam logic [7:0] CARD_ID1   = 8'h04;
  localparam logic [7:0] CARD_ID4   = 8'h80;

  // Store access: one read or one write per cycle
  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [STORE_ADDR_W-1:0] addr;
    logic [7:0]              wdata;
  } store_req_t;

  // Flag byte: the blank-card flag sits in bit 3, all other bits zero
  function automatic logic [7:0] flag_byte(input logic blank);
    flag_byte = {4'b0000, blank, 3'b000};
  endfunction

endpackage

@@ rtl/mcsp_store.sv @@
// ============================================================================
// mcsp_store - sector store
// Single-port synchronous byte memory; read data is registered and holds
// until the next read.
// ============================================================================
module mcsp_store (
  input  logic                clk,
  input  mcsp_pkg::store_req_t req,
  output logic [7:0]          rdata
);
  import mcsp_pkg::*;

  logic [7:0] mem [STORE_DEPTH];

  // Write or read one byte
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

@@ rtl/memory_card_serial_protocol_unit.sv @@
// ============================================================================
// memory_card_serial_protocol_unit - card side of a byte-serial card link
// Every host byte steps the command state machine; read and write commands
// move one 128-byte sector between the link and the sector store.
// ============================================================================
//
//  channel   direction  tdata           tuser
//  s_axis    in         rx_byte[7:0]    -
//  m_axis    out        tx_byte[7:0]    [0] drives_reply, [1] acknowledge
//
// One transaction in, one transaction out; a byte is accepted every cycle while the
// output is not stalled and the store is not being cleared. The reply to a byte is
// on the output in the cycle after the byte is taken: the store read of a sector
// byte is registered in the store and lands in the same cycle as the output register.
// After reset the store is cleared one byte per cycle, all 131072 bytes, with
// s_axis_tready low.
// A stalled output holds the result; a new byte is taken in the same cycle
// that the waiting result is taken.
module memory_card_serial_protocol_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic [1:0] m_axis_tuser    // [0] drives_reply, [1] acknowledge
);
  import mcsp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_COMMAND,
    ST_RD_ID1, ST_RD_ID2, ST_RD_AMSB, ST_RD_ALSB, ST_RD_ACK1, ST_RD_ACK2,
    ST_RD_CMSB, ST_RD_CLSB, ST_RD_DATA, ST_RD_SUM, ST_RD_END,
    ST_WR_ID1, ST_WR_ID2, ST_WR_AMSB, ST_WR_ALSB, ST_WR_DATA, ST_WR_SUM,
    ST_WR_ACK1, ST_WR_ACK2, ST_WR_END,
    ST_ID_ID1, ST_ID_ID2, ST_ID_ACK1, ST_ID_ACK2,
    ST_ID_B1, ST_ID_B2, ST_ID_B3, ST_ID_B4
  } state_t;

  // Where the output byte comes from
  typedef enum logic [1:0] {
    K_FIXED, K_RDDATA, K_WRDATA, K_SUM
  } kind_t;

  localparam logic [OFFSET_W-1:0]     OFFSET_LAST = OFFSET_W'(SECTOR_BYTES - 1);
  localparam logic [STORE_ADDR_W-1:0] CLEAR_LAST  = STORE_ADDR_W'(STORE_DEPTH - 1);

  // Protocol state
  state_t              state, state_next;
  logic [SECTOR_W-1:0] sector_address, sector_address_next;
  logic [OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic [7:0]          previous_rx;
  logic                card_blank, card_blank_next;
  logic [7:0]          checksum, checksum_next;

  // Output register
  logic       s1_valid;
  logic [7:0] s1_tx, s1_tx_next;
  logic       s1_drive, s1_drive_next;
  logic       s1_ack, s1_ack_next;
  kind_t      s1_kind, s1_kind_next;
  logic       s1_first, s1_first_next;
  logic [7:0] s1_seed, s1_seed_next;

  // Store clearing pass
  logic                    clr_active;
  logic [STORE_ADDR_W-1:0] clr_addr;

  store_req_t store_req;
  logic [7:0] store_rdata;

  logic       in_acc, out_acc;
  logic [7:0] rx;
  logic [7:0] addr_sum;
  logic       first_byte;

  assign rx            = s_axis_tdata;
  assign s_axis_tready = !clr_active && (!s1_valid || m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign addr_sum      = {6'b000000, sector_address[SECTOR_W-1:8]} ^ sector_address[7:0];
  assign first_byte    = (byte_offset == '0);

  // Decode the received byte
  always_comb begin
    state_next          = state;
    sector_address_next = sector_address;
    byte_offset_next    = byte_offset;
    card_blank_next     = card_blank;
    s1_tx_next          = REPLY_IDLE;
    s1_drive_next       = 1'b1;
    s1_ack_next         = 1'b1;
    s1_kind_next        = K_FIXED;
    s1_first_next       = first_byte;
    s1_seed_next        = '0;
    unique case (state)
      ST_COMMAND: begin
        s1_tx_next = flag_byte(card_blank);
        if (rx == CMD_READ) begin
          state_next = ST_RD_ID1;
        end else if (rx == CMD_WRITE) begin
          state_next = ST_WR_ID1;
        end else if (rx == CMD_GET_ID) begin
          state_next = ST_ID_ID1;
        end else begin
          s1_ack_next = 1'b0;
          state_next  = ST_IDLE;
        end
      end
      ST_RD_ID1, ST_WR_ID1, ST_ID_ID1: begin
        s1_tx_next = REPLY_ID1;
        state_next = state_t'(state + 5'd1);
      end
      ST_RD_ID2, ST_WR_ID2, ST_ID_ID2: begin
        s1_tx_next = REPLY_ID2;
        state_next = state_t'(state + 5'd1);
      end
      ST_RD_AMSB, ST_WR_AMSB: begin
        s1_tx_next          = REPLY_ZERO;
        sector_address_next = {rx[SECTOR_W-9:0], sector_address[7:0]};
        state_next          = state_t'(state + 5'd1);
      end
      ST_RD_ALSB, ST_WR_ALSB: begin
        s1_tx_next          = previous_rx;
        sector_address_next = {sector_address[SECTOR_W-1:8], rx};
        byte_offset_next    = '0;
        state_next          = state_t'(state + 5'd1);
      end
      ST_RD_ACK1, ST_WR_ACK1, ST_ID_ACK1: begin
        s1_tx_next = REPLY_ACK1;
        state_next = state_t'(state + 5'd1);
      end
      ST_RD_ACK2, ST_WR_ACK2, ST_ID_ACK2: begin
        s1_tx_next = REPLY_ACK2;
        state_next = state_t'(state + 5'd1);
      end
      ST_RD_CMSB: begin
        s1_tx_next = {6'b000000, sector_address[SECTOR_W-1:8]};
        state_next = ST_RD_CLSB;
      end
      ST_RD_CLSB: begin
        s1_tx_next = sector_address[7:0];
        state_next = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        s1_kind_next     = K_RDDATA;
        s1_seed_next     = first_byte ? addr_sum : 8'h00;
        byte_offset_next = byte_offset + OFFSET_W'(1);
        if (byte_offset == OFFSET_LAST) begin
          state_next = ST_RD_SUM;
        end
      end
      ST_RD_SUM, ST_WR_SUM: begin
        s1_kind_next = K_SUM;
        state_next   = state_t'(state + 5'd1);
      end
      ST_RD_END: begin
        s1_tx_next = REPLY_END;
        state_next = ST_IDLE;
      end
      ST_WR_DATA: begin
        s1_kind_next     = K_WRDATA;
        s1_tx_next       = previous_rx;
        s1_seed_next     = (first_byte ? addr_sum : 8'h00) ^ rx;
        byte_offset_next = byte_offset + OFFSET_W'(1);
        if (first_byte) begin
          card_blank_next = 1'b0;
        end
        if (byte_offset == OFFSET_LAST) begin
          state_next = ST_WR_SUM;
        end
      end
      ST_WR_END: begin
        s1_tx_next  = REPLY_END;
        s1_ack_next = 1'b0;
        state_next  = ST_IDLE;
      end
      ST_ID_B1: begin
        s1_tx_next = CARD_ID1;
        state_next = ST_ID_B2;
      end
      ST_ID_B2: begin
        s1_tx_next = REPLY_ZERO;
        state_next = ST_ID_B3;
      end
      ST_ID_B3: begin
        s1_tx_next = REPLY_ZERO;
        state_next = ST_ID_B4;
      end
      ST_ID_B4: begin
        s1_tx_next = CARD_ID4;
        state_next = ST_COMMAND;
      end
      default: begin
        if (rx == CMD_SELECT) begin
          state_next = ST_COMMAND;
        end else begin
          state_next    = ST_IDLE;
          s1_drive_next = 1'b0;
          s1_ack_next   = 1'b0;
        end
      end
    endcase
  end

  // Fold the leaving byte into the checksum
  always_comb begin
    checksum_next = checksum;
    case (s1_kind)
      K_RDDATA: checksum_next = (s1_first ? 8'h00 : checksum) ^ s1_seed ^ store_rdata;
      K_WRDATA: checksum_next = (s1_first ? 8'h00 : checksum) ^ s1_seed;
      default:  checksum_next = checksum;
    endcase
  end

  // Drive the store: clearing pass first, then item accesses
  always_comb begin
    if (clr_active) begin
      store_req.we    = 1'b1;
      store_req.re    = 1'b0;
      store_req.addr  = clr_addr;
      store_req.wdata = 8'h00;
    end else begin
      store_req.we    = in_acc && (state == ST_WR_DATA);
      store_req.re    = in_acc && (state == ST_RD_DATA);
      store_req.addr  = {sector_address, byte_offset};
      store_req.wdata = rx;
    end
  end

  mcsp_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (store_rdata)
  );

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      sector_address <= '0;
      byte_offset    <= '0;
      previous_rx    <= '0;
      card_blank     <= 1'b1;
      checksum       <= '0;
      s1_valid       <= 1'b0;
      clr_active     <= 1'b1;
      clr_addr       <= '0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + STORE_ADDR_W'(1);
        if (clr_addr == CLEAR_LAST) begin
          clr_active <= 1'b0;
        end
      end
      if (out_acc) begin
        checksum <= checksum_next;
      end
      if (in_acc) begin
        state          <= state_next;
        sector_address <= sector_address_next;
        byte_offset    <= byte_offset_next;
        previous_rx    <= rx;
        card_blank     <= card_blank_next;
        s1_valid       <= 1'b1;
        s1_tx          <= s1_tx_next;
        s1_drive       <= s1_drive_next;
        s1_ack         <= s1_ack_next;
        s1_kind        <= s1_kind_next;
        s1_first       <= s1_first_next;
        s1_seed        <= s1_seed_next;
      end else if (out_acc) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Select the output byte
  always_comb begin
    case (s1_kind)
      K_RDDATA: m_axis_tdata = store_rdata;
      K_SUM:    m_axis_tdata = checksum;
      default:  m_axis_tdata = s1_tx;
    endcase
  end

  assign m_axis_tvalid = s1_valid;
  assign m_axis_tuser  = {s1_ack, s1_drive};

  // No byte is taken while the store is being cleared
  a_clear_blocks_input: assert property (@(posedge clk)
    clr_active |-> !s_axis_tready)
    else $error("byte accepted during store clearing");

  // A sector read always lines up with the store read issued in the cycle before
  a_read_lines_up: assert property (@(posedge clk) disable iff (rst)
    (in_acc && state == ST_RD_DATA) |=> (s1_valid && s1_kind == K_RDDATA))
    else $error("sector read not followed by its data");

  // Once written, the card never reports a blank card again
  a_flag_sticks: assert property (@(posedge clk) disable iff (rst)
    !card_blank |=> !card_blank)
    else $error("blank-card flag set again");

  // The byte offset stays zero outside the data phases
  a_offset_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RD_DATA && state != ST_WR_DATA) |-> (byte_offset == '0))
    else $error("byte offset left nonzero");

  // A byte the card does not drive reads as idle with no acknowledge
  a_undriven_idle: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_drive) |-> (m_axis_tdata == REPLY_IDLE && !s1_ack))
    else $error("undriven reply not idle");

endmodule
